// File: sv/lpl_pkg.sv
// Package for the look-ahead peak limiter: payload structs, lane control and status
// structs, controller states and shared constants.
// Depends on nothing; every other file of the block uses it.

package lpl_pkg;

   // Field widths fixed by the item formats.
   localparam int SAMPLE_W  = 24;
   localparam int THR_W     = 23;
   localparam int HW_W      = 9;
   localparam int GAIN_W    = 33;   // Q1.32 gain, unsigned
   localparam int SLOPE_W   = 34;   // Q2.32 slope, signed
   localparam int WGAIN_W   = 17;   // Q1.16 window gain
   localparam int QGAIN_W   = 16;   // a lane quotient is always below unity
   localparam int MAX_CHANNELS = 2;

   // Parameter defaults.
   localparam int DELAY_DEPTH_DEF = 1024;
   localparam int CHANNELS_DEF    = 2;

   // Reset values.
   localparam logic [THR_W-1:0]   THRESHOLD_RST   = 23'd2097152;
   localparam logic [HW_W-1:0]    HALF_WINDOW_RST = 9'd256;
   localparam logic [WGAIN_W-1:0] UNITY_Q16       = 17'h10000;
   localparam logic [GAIN_W-1:0]  UNITY_Q32       = 33'h1_0000_0000;

   // Lane divider length: one quotient bit per cycle.
   localparam int LANE_DIV_STEPS = QGAIN_W;

   // Slope divider: two quotient bits per cycle over the even-width magnitude.
   localparam int SLOPE_DIV_STEPS = SLOPE_W / 2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD   = 1'b0,
      CSR_HALF_WINDOW = 1'b1
   } csr_index_type;

   // Input and result items.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] ch1_sample;
      logic signed [SAMPLE_W-1:0] ch0_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] ch1_out;
      logic signed [SAMPLE_W-1:0] ch0_out;
   } rsp_type;

   // Controller to lane.
   typedef struct packed {
      logic start;   // item accepted: store sample, fetch delayed sample, start divide
      logic mul;     // scale the delayed sample by the current gain
   } lane_ctrl_type;

   // Lane to merging stage.
   typedef struct packed {
      logic               busy;
      logic               hit;       // sample magnitude above threshold
      logic [QGAIN_W-1:0] win_gain;  // threshold / |x| in Q0.16
   } lane_stat_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_DELIVER
   } state_type;

endpackage

// File: sv/lpl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Takes its parameter defaults from lpl_pkg; used for each channel's delay line.

module lpl_ram #(
   parameter int WIDTH = lpl_pkg::SAMPLE_W,
   parameter int DEPTH = lpl_pkg::DELAY_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/lpl_lane.sv
// One channel lane of the limiter: delay line, window gain divider and output scaling.
// Depends on lpl_pkg and lpl_ram.

module lpl_lane #(
   parameter int DELAY_DEPTH = lpl_pkg::DELAY_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lpl_pkg::lane_ctrl_type              ctrl,
   input  logic signed [lpl_pkg::SAMPLE_W-1:0] sample,
   input  logic [lpl_pkg::THR_W-1:0]           threshold,
   input  logic [$clog2(DELAY_DEPTH)-1:0]      wr_addr,
   input  logic [$clog2(DELAY_DEPTH)-1:0]      rd_addr,
   input  logic                                rd_valid,
   input  logic [lpl_pkg::GAIN_W-1:0]          gain,
   output lpl_pkg::lane_stat_type              stat,
   output logic signed [lpl_pkg::SAMPLE_W-1:0] out_sample
);

   localparam int SW  = lpl_pkg::SAMPLE_W;
   localparam int QW  = lpl_pkg::QGAIN_W;
   localparam int CNW = $clog2(lpl_pkg::LANE_DIV_STEPS + 1);
   localparam int PW  = SW + lpl_pkg::GAIN_W;

   logic [SW-1:0]         abs_c;
   logic                  hit_c;
   logic [SW-1:0]         abs_ff, abs_in;
   logic                  hit_ff, hit_in;
   logic [SW-1:0]         rem_ff, rem_in;
   logic [QW-1:0]         quo_ff, quo_in;
   logic [CNW-1:0]        cnt_ff, cnt_in;
   logic                  rd_valid_ff;
   logic [SW:0]           rem_sh_c;
   logic [SW-1:0]         rd_data;
   logic signed [SW-1:0]  delayed_c;
   logic signed [PW-1:0]  prod_c;
   logic signed [SW-1:0]  out_ff, out_in;

   // Delay line storage for this channel.
   lpl_ram #(
      .WIDTH (SW),
      .DEPTH (DELAY_DEPTH)
   ) u_delay (
      .clock   (clock),
      .wr_en   (ctrl.start),
      .wr_addr (wr_addr),
      .wr_data (sample),
      .rd_en   (ctrl.start),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Magnitude of the incoming sample; the most negative code maps to 2^23.
   always_comb begin
      abs_c = sample[SW-1] ? (~sample + SW'(1)) : sample;
      hit_c = abs_c > {1'b0, threshold};
   end

   // Restoring divider for threshold * 2^16 / |x|. The quotient is below 2^16
   // whenever |x| exceeds the threshold, so the remainder starts at the threshold.
   always_comb begin
      abs_in   = abs_ff;
      hit_in   = hit_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      rem_sh_c = {rem_ff, 1'b0};
      if (ctrl.start) begin
         abs_in = abs_c;
         hit_in = hit_c;
         rem_in = {1'b0, threshold};
         quo_in = '0;
         cnt_in = hit_c ? CNW'(lpl_pkg::LANE_DIV_STEPS) : '0;
      end else if (cnt_ff != '0) begin
         if (rem_sh_c >= {1'b0, abs_ff}) begin
            rem_in = SW'(rem_sh_c - {1'b0, abs_ff});
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh_c[SW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      abs_ff <= abs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (ctrl.start) begin
         rd_valid_ff <= rd_valid;
      end
   end

   assign stat.busy     = cnt_ff != '0;
   assign stat.hit      = hit_ff;
   assign stat.win_gain = quo_ff;

   // Output scaling: entries never written read as zero. Unity gain passes the
   // sample through; otherwise the top bits of the product give a floor shift.
   always_comb begin
      delayed_c = rd_valid_ff ? $signed(rd_data) : '0;
      prod_c    = delayed_c * $signed({1'b0, gain[lpl_pkg::GAIN_W-2:0]});
      out_in    = gain[lpl_pkg::GAIN_W-1] ? delayed_c : prod_c[PW-2:PW-1-SW];
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         out_ff <= out_in;
      end
   end

   assign out_sample = out_ff;

endmodule

// File: sv/lpl_slope_div.sv
// Signed divider for the gain slope: (target - gain) / half_window, truncated toward zero.
// Two quotient bits per cycle. Depends on lpl_pkg.

module lpl_slope_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [lpl_pkg::SLOPE_W-1:0]  dividend,
   input  logic [lpl_pkg::HW_W-1:0]            divisor,
   output logic                                busy,
   output logic signed [lpl_pkg::SLOPE_W-1:0]  quotient
);

   localparam int NW  = lpl_pkg::SLOPE_W;
   localparam int DW  = lpl_pkg::HW_W;
   localparam int CNW = $clog2(lpl_pkg::SLOPE_DIV_STEPS + 1);

   logic [NW-1:0]  mag_ff, mag_in;
   logic [DW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  div_ff, div_in;
   logic           neg_ff, neg_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [DW:0]    r1_c, r2_c;
   logic [DW-1:0]  rem1_c;
   logic           q1_c, q2_c;

   // Two restoring steps per cycle on the narrow remainder; quotient bits shift
   // into the bottom of the magnitude register as the dividend bits leave the top.
   always_comb begin
      r1_c   = {rem_ff, mag_ff[NW-1]};
      q1_c   = r1_c >= {1'b0, div_ff};
      rem1_c = q1_c ? DW'(r1_c - {1'b0, div_ff}) : r1_c[DW-1:0];
      r2_c   = {rem1_c, mag_ff[NW-2]};
      q2_c   = r2_c >= {1'b0, div_ff};

      mag_in = mag_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (start) begin
         neg_in = dividend[NW-1];
         mag_in = dividend[NW-1] ? NW'(-dividend) : dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = CNW'(lpl_pkg::SLOPE_DIV_STEPS);
      end else if (cnt_ff != '0) begin
         rem_in = q2_c ? DW'(r2_c - {1'b0, div_ff}) : r2_c[DW-1:0];
         mag_in = {mag_ff[NW-3:0], q1_c, q2_c};
         cnt_in = cnt_ff - CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);

endmodule

// File: sv/lookahead_peak_limiter_top.sv
// Top level of the stereo look-ahead peak limiter: controller, gain ramp and merging stage.
// Depends on lpl_pkg, lpl_lane (with lpl_ram) and lpl_slope_div.
//
// Usage:
// - Input items arrive on req_valid / req_ready / req_data, one sample per channel.
//   Result items leave on rsp_valid / rsp_ready / rsp_data, one per input item.
// - The user must write registers via csr_we / csr_index / csr_wdata only while no item
//   is in flight; the block leaves it unchecked. Index 0: threshold, index 1: half window.
// - Items are processed one at a time. An item goes from acceptance through the divide,
//   multiply and deliver states to a valid result; the divide state waits while the slope
//   divider runs its 17 steps on a window start or a lane divider its 16 steps when a
//   sample exceeds the threshold, and the dividers overlap. The next item is accepted the
//   cycle after a result is loaded.
// - The result register parts the two sides: a new item is accepted while the
//   previous result still waits. If the receiver stalls, the next item stops just
//   before delivery and req_ready stays low until the result register frees up.
// - After reset the gain is unity, both window minima are unity, and the delay
//   lines read as zero until written, tracked by the write pointer and a wrap flag;
//   no clearing pass is needed.

module lookahead_peak_limiter_top #(
   parameter int DELAY_DEPTH = lpl_pkg::DELAY_DEPTH_DEF,
   parameter int CHANNELS    = lpl_pkg::CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lpl_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lpl_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [lpl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lpl_pkg::THR_W-1:0]         csr_wdata
);

   localparam int AW  = $clog2(DELAY_DEPTH);
   localparam int CW  = (AW > lpl_pkg::HW_W + 1 ? AW : lpl_pkg::HW_W + 1) + 1;
   localparam int SW  = lpl_pkg::SAMPLE_W;
   localparam int GW  = lpl_pkg::GAIN_W;
   localparam int LW  = lpl_pkg::SLOPE_W;
   localparam int WW  = lpl_pkg::WGAIN_W;
   localparam int HW  = lpl_pkg::HW_W;
   localparam int MC  = lpl_pkg::MAX_CHANNELS;

   lpl_pkg::state_type     state_ff, state_in;
   logic [lpl_pkg::THR_W-1:0] threshold_ff;
   logic [HW-1:0]          half_window_ff;
   logic [AW-1:0]          wp_ff, wp_in;
   logic                   wrapped_ff, wrapped_in;
   logic [HW-1:0]          phase_ff, phase_in;
   logic [GW-1:0]          gain_ff, gain_in;
   logic signed [LW-1:0]   slope_ff, slope_in;
   logic [WW-1:0]          wmin_ff, wmin_in;
   logic [WW-1:0]          pwmin_ff, pwmin_in;
   logic                   new_window_ff, new_window_in;
   lpl_pkg::rsp_type       rsp_data_ff, rsp_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   accept;
   logic                   merge_en;
   logic                   load_rsp;
   logic                   all_idle;
   logic [HW-1:0]          hw_eff;
   logic [CW-1:0]          delay_c;
   logic [CW-1:0]          rd_sum_c;
   logic [AW-1:0]          rd_addr;
   logic                   rd_valid;
   logic [HW:0]            phase_inc;
   logic [WW-1:0]          min_m;
   logic signed [LW-1:0]   diff_c;
   logic                   div_busy;
   logic signed [LW-1:0]   div_q;
   logic signed [LW-1:0]   slope_use;
   logic signed [LW:0]     gain_sum;
   logic [WW-1:0]          lane_min;

   lpl_pkg::lane_ctrl_type lane_ctrl;
   lpl_pkg::lane_stat_type lane_stat [MC];
   logic signed [SW-1:0]   lane_out  [MC];
   logic signed [SW-1:0]   lane_in   [MC];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= lpl_pkg::THRESHOLD_RST;
         half_window_ff <= lpl_pkg::HALF_WINDOW_RST;
      end else if (csr_we) begin
         case (lpl_pkg::csr_index_type'(csr_index))
            lpl_pkg::CSR_THRESHOLD:   threshold_ff   <= csr_wdata;
            lpl_pkg::CSR_HALF_WINDOW: half_window_ff <= csr_wdata[HW-1:0];
            default: ;
         endcase
      end
   end

   // Controller: next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpl_pkg::ST_IDLE:     if (accept)   state_in = lpl_pkg::ST_DIVIDE;
         lpl_pkg::ST_DIVIDE:   if (all_idle) state_in = lpl_pkg::ST_MULTIPLY;
         lpl_pkg::ST_MULTIPLY: state_in = lpl_pkg::ST_DELIVER;
         lpl_pkg::ST_DELIVER:  if (load_rsp) state_in = lpl_pkg::ST_IDLE;
         default:              state_in = lpl_pkg::ST_IDLE;
      endcase
   end

   // Controller: outputs.
   always_comb begin
      req_ready     = 1'b0;
      merge_en      = 1'b0;
      lane_ctrl.mul = 1'b0;
      load_rsp      = 1'b0;
      case (state_ff)
         lpl_pkg::ST_IDLE:     req_ready     = 1'b1;
         lpl_pkg::ST_DIVIDE:   merge_en      = all_idle;
         lpl_pkg::ST_MULTIPLY: lane_ctrl.mul = 1'b1;
         lpl_pkg::ST_DELIVER:  load_rsp      = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign accept          = req_valid && req_ready;
   assign lane_ctrl.start = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Delay length and read address; an address below the write pointer, or any
   // address once the pointer has wrapped, holds a stored sample.
   always_comb begin
      hw_eff  = (half_window_ff == '0) ? HW'(1) : half_window_ff;
      delay_c = CW'({hw_eff, 1'b0});
      if (delay_c > CW'(DELAY_DEPTH - 1)) begin
         delay_c = CW'(DELAY_DEPTH - 1);
      end
      if (CW'(wp_ff) >= delay_c) begin
         rd_sum_c = CW'(wp_ff) - delay_c;
      end else begin
         rd_sum_c = CW'(wp_ff) + CW'(DELAY_DEPTH) - delay_c;
      end
      rd_addr  = rd_sum_c[AW-1:0];
      rd_valid = wrapped_ff || (rd_addr < wp_ff);
   end

   // Window start: ramp target and slope division inputs.
   always_comb begin
      min_m  = (wmin_ff < pwmin_ff) ? wmin_ff : pwmin_ff;
      diff_c = $signed({1'b0, min_m, 16'h0000}) - $signed({1'b0, gain_ff});
   end

   lpl_slope_div u_slope_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && (phase_ff == '0)),
      .dividend (diff_c),
      .divisor  (hw_eff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // Channel lanes; absent channels are tied off.
   for (genvar ch = 0; ch < MC; ch++) begin : g_lane
      assign lane_in[ch] = (ch == 0) ? req_data.ch0_sample : req_data.ch1_sample;
      if (ch < CHANNELS) begin : g_on
         lpl_lane #(
            .DELAY_DEPTH (DELAY_DEPTH)
         ) u_lane (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (lane_ctrl),
            .sample     (lane_in[ch]),
            .threshold  (threshold_ff),
            .wr_addr    (wp_ff),
            .rd_addr    (rd_addr),
            .rd_valid   (rd_valid),
            .gain       (gain_ff),
            .stat       (lane_stat[ch]),
            .out_sample (lane_out[ch])
         );
      end else begin : g_off
         assign lane_stat[ch] = '0;
         assign lane_out[ch]  = '0;
      end
   end

   // Merging stage: lanes and slope divider idle, smallest of the window minimum and the hit lanes' gains.
   always_comb begin
      all_idle = !div_busy;
      lane_min = wmin_ff;
      for (int i = 0; i < MC; i++) begin
         if (lane_stat[i].busy) begin
            all_idle = 1'b0;
         end
         if (lane_stat[i].hit && ({1'b0, lane_stat[i].win_gain} < lane_min)) begin
            lane_min = {1'b0, lane_stat[i].win_gain};
         end
      end
   end

   // Gain ramp step with saturation to [0, unity].
   always_comb begin
      slope_use = new_window_ff ? div_q : slope_ff;
      gain_sum  = $signed({2'b00, gain_ff}) + $signed({slope_use[LW-1], slope_use});
   end

   // Item bookkeeping and ramp state.
   always_comb begin
      wp_in         = wp_ff;
      wrapped_in    = wrapped_ff;
      phase_in      = phase_ff;
      new_window_in = new_window_ff;
      wmin_in       = wmin_ff;
      pwmin_in      = pwmin_ff;
      slope_in      = slope_ff;
      gain_in       = gain_ff;
      phase_inc     = {1'b0, phase_ff} + (HW + 1)'(1);
      if (accept) begin
         new_window_in = phase_ff == '0;
         if (phase_ff == '0) begin
            pwmin_in = wmin_ff;
            wmin_in  = lpl_pkg::UNITY_Q16;
         end
         if (wp_ff == AW'(DELAY_DEPTH - 1)) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + AW'(1);
         end
         phase_in = (phase_inc >= {1'b0, hw_eff}) ? '0 : phase_inc[HW-1:0];
      end
      if (merge_en) begin
         wmin_in  = lane_min;
         slope_in = slope_use;
         if (gain_sum < 0) begin
            gain_in = '0;
         end else if (gain_sum > $signed({2'b00, lpl_pkg::UNITY_Q32})) begin
            gain_in = lpl_pkg::UNITY_Q32;
         end else begin
            gain_in = gain_sum[GW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         wrapped_ff    <= 1'b0;
         phase_ff      <= '0;
         new_window_ff <= 1'b0;
         wmin_ff       <= lpl_pkg::UNITY_Q16;
         pwmin_ff      <= lpl_pkg::UNITY_Q16;
         slope_ff      <= '0;
         gain_ff       <= lpl_pkg::UNITY_Q32;
      end else begin
         wp_ff         <= wp_in;
         wrapped_ff    <= wrapped_in;
         phase_ff      <= phase_in;
         new_window_ff <= new_window_in;
         wmin_ff       <= wmin_in;
         pwmin_ff      <= pwmin_in;
         slope_ff      <= slope_in;
         gain_ff       <= gain_in;
      end
   end

   // Result register.
   always_comb begin
      rsp_data_in         = rsp_data_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      if (load_rsp) begin
         rsp_data_in.ch0_out = lane_out[0];
         rsp_data_in.ch1_out = lane_out[1];
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
